// ===== sv/fdl_pkg.sv =====
package fdl_pkg;

  localparam int LineDepth = 4096;
  localparam int AddrW = $clog2(LineDepth);

  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_INT     = 3'd1;
  localparam logic [2:0] OP_LINEAR  = 3'd2;
  localparam logic [2:0] OP_HERMITE = 3'd3;
  localparam logic [2:0] OP_HYBRID  = 3'd4;

  localparam logic signed [32:0] BlendH = 33'sh059999999;
  localparam logic signed [32:0] BlendL = 33'sh026666666;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_FIN, ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       clr_wr;
    logic       wr;
    logic       rd;
    logic [1:0] rd_sel;
    logic       cap;
    logic [2:0] cap_sel;
    logic       mul;
    logic [2:0] mstep;
    logic       load;
    logic       out_load;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -36'sh080000000) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== sv/fdl_datapath.sv =====
module fdl_datapath (
  input  logic                         clk,
  input  fdl_pkg::cmd_t                cmd,
  input  logic [2:0]                   op,
  input  logic signed [31:0]           sample_in,
  input  logic [11:0]                  delay_int,
  input  logic [27:0]                  delay_fixed,
  input  logic [fdl_pkg::AddrW-1:0]    clr_addr,
  output logic signed [31:0]           sample_out
);
  import fdl_pkg::*;

  logic signed [31:0] mem [LineDepth];
  logic signed [31:0] rdata;
  logic [AddrW-1:0] wp, base, raddr;
  logic [2:0] op_r;
  logic [15:0] f;
  logic [11:0] dsamp;
  logic signed [31:0] xm1, x0, x1, x2;
  logic signed [33:0] c1;
  logic signed [36:0] c2, c3;
  logic [15:0] t2, t3;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] lin, herm;
  logic signed [35:0] rsum;

  // hold item fields, keep write pointer
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      wp <= '0;
    end else if (cmd.wr) begin
      wp <= wp + 1'b1;
    end
    if (cmd.load) begin
      op_r  <= op;
      f     <= delay_fixed[15:0];
      dsamp <= delay_int;
      base  <= wp - AddrW'(delay_fixed[27:16]);
    end
  end

  // address: OP_INT wp - dsamp; else offsets 0,-1,-2,-3 from base (xm1, x0, x1, x2)
  always_comb begin
    if (op_r == OP_INT) raddr = wp - AddrW'(dsamp);
    else raddr = base - AddrW'(cmd.rd_sel);
  end

  // store port
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem[clr_addr] <= '0;
    else if (cmd.wr) mem[wp] <= sample_in;
    if (cmd.rd) rdata <= mem[raddr];
  end

  // capture taps
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      unique case (cmd.cap_sel)
        3'd0: xm1 <= rdata;
        3'd1: x0 <= rdata;
        3'd2: x1 <= rdata;
        default: x2 <= rdata;
      endcase
    end
  end

  // one multiply per step
  always_comb begin
    unique case (cmd.mstep)
      3'd0: prod = 64'(signed'({1'b0, f})) * 64'(signed'({1'b0, f}));
      3'd1: prod = 64'(signed'({1'b0, t2})) * 64'(signed'({1'b0, f}));
      3'd2: prod = 64'(c1) * 64'(signed'({1'b0, f}));
      3'd3: prod = 64'(c2) * 64'(signed'({1'b0, t2}));
      3'd4: prod = 64'(c3) * 64'(signed'({1'b0, t3}));
      3'd5: prod = 64'(33'(x0) - 33'(xm1)) * 64'(signed'({1'b0, f}));
      3'd6: prod = 64'(herm) * 64'(BlendH);
      default: prod = 64'(lin) * 64'(BlendL);
    endcase
  end

  always_comb rsum = 36'(acc) - 36'(acc >>> 4);

  always_ff @(posedge clk) begin
    if (cmd.cap && cmd.cap_sel == 3'd3) begin
      c1 <= (34'(x1) - 34'(xm1)) >>> 2;
      c2 <= 37'(xm1) - (37'(35'(x0) * 35'sd5) >>> 1) + 37'(x1) * 37'sd2 -
            37'(rdata >>> 1);
      c3 <= ((37'(rdata) - 37'(xm1)) >>> 2) + 37'(x0) - 37'(x1);
    end
    // advance the multiply sequence only while the controller runs it
    if (cmd.mul) begin
      unique case (cmd.mstep)
        3'd0: t2 <= prod[31:16];
        3'd1: t3 <= prod[31:16];
        3'd2: acc <= 64'(x0) + (prod >>> 16);
        3'd3, 3'd4: acc <= acc + (prod >>> 16);
        3'd5: lin <= sat32(36'(xm1) + 36'(signed'(prod[47:16])));
        3'd6: acc <= prod >>> 31;
        default: acc <= acc + (prod >>> 31);
      endcase
    end
    if (cmd.out_load) begin
      unique case (op_r)
        OP_INT: sample_out <= rdata;
        OP_LINEAR: sample_out <= lin;
        OP_HERMITE: sample_out <= herm;
        default: sample_out <= sat32(36'(acc));
      endcase
    end
    if (cmd.cap_sel == 3'd7) herm <= sat32(rsum);
  end
endmodule

// ===== sv/fdl_ctrl.sv =====
module fdl_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                op,
  output logic                      out_valid,
  input  logic                      out_stall,
  output fdl_pkg::cmd_t             cmd,
  output logic [fdl_pkg::AddrW-1:0] clr_addr
);
  import fdl_pkg::*;

  state_t state, state_next;
  logic [2:0] op_r;
  logic [AddrW-1:0] cnt;
  logic [3:0] step;
  logic accept;

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign clr_addr = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt <= '0;
      out_valid <= 1'b0;
      step <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) cnt <= cnt + 1'b1;
      if (accept) op_r <= op;
      if (state == ST_M0) step <= step + 1'b1;
      else step <= '0;
      if (state == ST_FIN) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // sequence the clear pass, writes, reads then multiplies
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.cap_sel = 3'd0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (cnt == AddrW'(LineDepth - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (op == OP_WRITE) cmd.wr = 1'b1;
          else if (op == OP_INT || op == OP_LINEAR || op == OP_HERMITE ||
                   op == OP_HYBRID) state_next = ST_RD0;
        end
      end
      ST_RD0: begin cmd.rd = 1'b1; cmd.rd_sel = 2'd0; state_next = ST_RD1; end
      ST_RD1: begin
        cmd.rd = 1'b1; cmd.rd_sel = 2'd1; cmd.cap = 1'b1; cmd.cap_sel = 3'd0;
        state_next = (op_r == OP_INT) ? ST_OUT : ST_RD2;
      end
      ST_RD2: begin
        cmd.rd = 1'b1; cmd.rd_sel = 2'd2; cmd.cap = 1'b1; cmd.cap_sel = 3'd1;
        state_next = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd = 1'b1; cmd.rd_sel = 2'd3; cmd.cap = 1'b1; cmd.cap_sel = 3'd2;
        state_next = ST_RD4;
      end
      ST_RD4: begin cmd.cap = 1'b1; cmd.cap_sel = 3'd3; state_next = ST_M0; end
      ST_M0: begin
        // steps: t2,t3,c1f,c2t2,c3t3,lin,(herm),blendH,blendL
        cmd.mul = 1'b1;
        unique case (step)
          4'd0: cmd.mstep = 3'd0;
          4'd1: cmd.mstep = 3'd1;
          4'd2: cmd.mstep = 3'd2;
          4'd3: cmd.mstep = 3'd3;
          4'd4: cmd.mstep = 3'd4;
          4'd5: cmd.mstep = 3'd5;
          4'd6: begin cmd.mstep = 3'd5; cmd.cap_sel = 3'd7; end
          4'd7: cmd.mstep = 3'd6;
          4'd8: cmd.mstep = 3'd7;
          default: cmd.mstep = 3'd5;
        endcase
        if ((op_r != OP_HYBRID && step == 4'd6) || step == 4'd8) state_next = ST_FIN;
      end
      ST_OUT: begin cmd.out_load = 1'b1; state_next = ST_FIN; end
      ST_FIN: begin
        if (op_r != OP_INT) cmd.out_load = 1'b1;
        state_next = ST_M1;
      end
      ST_M1: begin if (!out_valid || !out_stall) state_next = ST_IDLE; end
      default: state_next = ST_IDLE;
    endcase
  end

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !accept) else $error("accept during clear");
  a_out_after_fin: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |=> out_valid) else $error("result not shown");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD0 |-> in_stall) else $error("accept while busy");
endmodule

// ===== sv/fractional_delay_line.sv =====
// Fractional delay line: 4096 Q31 samples, cleared by a pass after reset
// during which no item is taken. One item is handled at a time. Reads run
// through one store port (up to four taps, one per cycle) and one shared
// multiplier; while the result is stalled, no next item is taken.
module fractional_delay_line (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] sample_in,
  input  logic [11:0]        delay_int,
  input  logic [27:0]        delay_fixed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] sample_out
);
  import fdl_pkg::*;

  cmd_t cmd;
  logic [AddrW-1:0] clr_addr;

  fdl_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .op, .out_valid, .out_stall,
    .cmd, .clr_addr);

  fdl_datapath u_dp (.clk, .cmd, .op, .sample_in, .delay_int, .delay_fixed,
    .clr_addr, .sample_out);
endmodule

// ===== verif/fdl_checker.sv =====
module fdl_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] sample_in,
  input  logic [11:0]        delay_int,
  input  logic [27:0]        delay_fixed,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] sample_out,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fdl_pkg::*;

  localparam logic [AddrW-1:0] IdxMask = AddrW'(LineDepth - 1);

  logic signed [31:0] line_mem [LineDepth];
  logic [AddrW-1:0]   wr_ptr;
  logic signed [31:0] expected_samples [$];

  function automatic longint clamp_q31(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint tap(logic [AddrW-1:0] idx);
    return longint'(line_mem[idx & IdxMask]);
  endfunction

  function automatic longint linear_sample(logic [AddrW-1:0] d, longint f);
    longint a, b, delta;
    logic signed [31:0] d32;
    a = tap(wr_ptr - d);
    b = tap(wr_ptr - d - 1'b1);
    delta = ((b - a) * f) >>> 16;
    d32 = delta[31:0];
    return clamp_q31(a + longint'(d32));
  endfunction

  function automatic longint hermite_sample(logic [AddrW-1:0] d, longint f);
    logic [AddrW-1:0] i0;
    longint xm1, x0, x1, x2, c1, c2, c3, t2, t3, r;
    i0 = wr_ptr - d - 1'b1;
    xm1 = tap(i0 + 1'b1);
    x0 = tap(i0);
    x1 = tap(i0 - 1'b1);
    x2 = tap(i0 - 2'd2);
    c1 = (x1 - xm1) >>> 2;
    c2 = xm1 - ((5 * x0) >>> 1) + 2 * x1 - (x2 >>> 1);
    c3 = ((x2 - xm1) >>> 2) + (x0 - x1);
    t2 = (f * f) >>> 16;
    t3 = (t2 * f) >>> 16;
    r = x0 + ((c1 * f) >>> 16) + ((c2 * t2) >>> 16) + ((c3 * t3) >>> 16);
    r = r - (r >>> 4);
    return clamp_q31(r);
  endfunction

  assign pending = expected_samples.size();

  // Track accepted items, update the line model, compare results
  always @(posedge clk) begin
    logic [AddrW-1:0] d;
    longint f, y, h, l;
    if (rst) begin
      foreach (line_mem[i]) line_mem[i] = '0;
      wr_ptr = '0;
      expected_samples.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample_out: actual %0d", sample_out);
          fail_count++;
        end else begin
          if (sample_out !== expected_samples[0]) begin
            $error("sample_out mismatch: expected %0d actual %0d",
                   expected_samples[0], sample_out);
            fail_count++;
          end
          void'(expected_samples.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        d = AddrW'(delay_fixed >> 16);
        f = longint'(delay_fixed[15:0]);
        case (op)
          OP_WRITE: begin
            line_mem[wr_ptr] = sample_in;
            wr_ptr = wr_ptr + 1'b1;
          end
          OP_INT: expected_samples.push_back(line_mem[wr_ptr - AddrW'(delay_int)]);
          OP_LINEAR: expected_samples.push_back(32'(linear_sample(d, f)));
          OP_HERMITE: expected_samples.push_back(32'(hermite_sample(d, f)));
          OP_HYBRID: begin
            h = (hermite_sample(d, f) * longint'(BlendH)) >>> 31;
            l = (linear_sample(d, f) * longint'(BlendL)) >>> 31;
            y = clamp_q31(h + l);
            expected_samples.push_back(32'(y));
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== verif/tb_fractional_delay_line.sv =====
module tb_fractional_delay_line;
  timeunit 1ns;
  timeprecision 1ps;
  import fdl_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         op;
  logic signed [31:0] sample_in;
  logic [11:0]        delay_int;
  logic [27:0]        delay_fixed;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] sample_out;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  fractional_delay_line dut (.*);

  fdl_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at the rate the current phase asks
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Hold one item until it is taken, after an optional idle gap
  task automatic send_item(logic [2:0] o, logic signed [31:0] s, logic [11:0] ds,
                           logic [27:0] dfx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    op            <= o;
    sample_in     <= s;
    delay_int     <= ds;
    delay_fixed   <= dfx;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Nearly half writes, mostly small fractional delays, with some full-range ones
  task automatic send_random;
    logic [2:0] o;
    logic signed [31:0] s;
    logic [27:0] dfx;
    o = ($urandom_range(9) < 4) ? OP_WRITE : 3'($urandom_range(7));
    case ($urandom_range(3))
      0: s = 32'sh7FFFFFFF - 32'($urandom_range(3));
      1: s = 32'sh80000000 + 32'($urandom_range(3));
      default: s = $urandom;
    endcase
    dfx = ($urandom_range(3) == 0) ? 28'($urandom) :
          {12'($urandom_range(40)), 16'($urandom)};
    send_item(o, s, 12'($urandom), dfx);
  endtask

  initial begin
    in_valid = 1'b0;
    op = OP_WRITE;
    sample_in = '0;
    delay_int = '0;
    delay_fixed = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reads of the cleared line, extremes, every op, odd codes
    send_item(OP_INT, 0, 12'hFFF, 28'h0);
    send_item(OP_HERMITE, 0, 0, 28'hFFFFFFF);
    send_item(OP_WRITE, 32'sh7FFFFFFF, 0, 0);
    send_item(OP_WRITE, 32'sh80000000, 0, 0);
    send_item(OP_WRITE, 32'sh7FFFFFFF, 0, 0);
    send_item(OP_WRITE, 32'sh80000000, 0, 0);
    send_item(OP_WRITE, 32'sh12345678, 0, 0);
    send_item(OP_INT, 0, 12'd1, 0);
    send_item(OP_INT, 0, 12'd0, 0);
    send_item(OP_LINEAR, 0, 0, 28'h0000FFFF);
    send_item(OP_LINEAR, 0, 0, 28'h00018000);
    send_item(OP_LINEAR, 0, 0, 28'h00028000);
    send_item(OP_HERMITE, 0, 0, 28'h0000FFFF);
    send_item(OP_HERMITE, 0, 0, 28'h00018000);
    send_item(OP_HERMITE, 0, 0, 28'h00020000);
    send_item(OP_HYBRID, 0, 0, 28'h0001FFFF);
    send_item(OP_HYBRID, 0, 0, 28'h0FFF0001);
    send_item(3'd5, 0, 0, 0);
    send_item(3'd6, 0, 0, 0);
    send_item(3'd7, 0, 0, 0);
    send_item(OP_INT, 0, 12'hFFF, 0);

    // Random phases with different idle and stall rates
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 37 : 66) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 37 : 66) : 0;
      for (int k = 0; k < 100; k++) begin
        send_random();
        // Drain once so a read finds the line fully settled
        if (phase == 1 && k == 50) begin
          in_valid <= 1'b0;
          @(negedge clk);
          wait (pending == 0);
        end
      end
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
